@@ hw/rtl/tlvf_pkg.sv @@
// Shared types and constants for the TLV tag value finder.
// No dependencies; used by tlvf_scan, tlvf_out_fifo and tlv_tag_value_finder.
package tlvf_pkg;

    localparam int BYTE_W = 8;

    // result item kinds
    localparam logic [1:0] KIND_LENGTH = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // scan phases
    localparam logic [1:0] PH_TAG1  = 2'd0;
    localparam logic [1:0] PH_TAG2  = 2'd1;
    localparam logic [1:0] PH_LEN   = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    // configuration register indexes
    localparam logic CFG_TARGET_FIRST  = 1'b0;
    localparam logic CFG_TARGET_SECOND = 1'b1;

    // low five bits all ones announce a second tag byte
    localparam logic [BYTE_W-1:0] TWO_BYTE_TAG_MASK = 8'h1F;

    typedef struct packed {
        logic [1:0]        item_kind;
        logic [BYTE_W-1:0] payload;
        logic              tag_found;
        logic              cut_short;
    } t_item;

    // what one processed byte puts into the result queue
    typedef struct packed {
        logic  push0;
        logic  push1;
        t_item item0;
        t_item item1;
    } t_push;

endpackage

@@ hw/rtl/tlvf_scan.sv @@
// Scan state machine: walks tag, length and value bytes, emits up to two results per byte.
// Depends on tlvf_pkg.
module tlvf_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [tlvf_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_eos,
    input  logic [tlvf_pkg::BYTE_W-1:0]  i_target_first,
    input  logic [tlvf_pkg::BYTE_W-1:0]  i_target_second,
    output tlvf_pkg::t_push              o_push
);

    logic [1:0]                    r_phase, n_phase;
    logic                          r_matches, n_matches;
    logic [tlvf_pkg::BYTE_W-1:0]   r_bytes_left, n_bytes_left;
    logic                          r_done, n_done;
    logic                          r_recorded, n_recorded;

    logic                          data_valid;
    tlvf_pkg::t_item               data_item;
    tlvf_pkg::t_item               status_item;
    logic [tlvf_pkg::BYTE_W-1:0]   left_dec;

    assign left_dec = r_bytes_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_matches    = r_matches;
        n_bytes_left = r_bytes_left;
        n_done       = r_done;
        n_recorded   = r_recorded;
        data_valid   = 1'b0;
        data_item    = '0;
        status_item  = '0;

        if (!r_done) begin
            unique case (r_phase)
                tlvf_pkg::PH_TAG1: begin
                    n_matches = (i_byte == i_target_first);
                    if ((i_byte & tlvf_pkg::TWO_BYTE_TAG_MASK) == tlvf_pkg::TWO_BYTE_TAG_MASK)
                        n_phase = tlvf_pkg::PH_TAG2;
                    else
                        n_phase = tlvf_pkg::PH_LEN;
                end
                tlvf_pkg::PH_TAG2: begin
                    n_matches = r_matches && (i_byte == i_target_second);
                    n_phase   = tlvf_pkg::PH_LEN;
                end
                tlvf_pkg::PH_LEN: begin
                    if (r_matches) begin
                        data_valid          = 1'b1;
                        data_item.item_kind = tlvf_pkg::KIND_LENGTH;
                        data_item.payload   = i_byte;
                        n_recorded          = 1'b1;
                        if (i_byte == '0)
                            n_done = 1'b1;
                    end
                    n_bytes_left = i_byte;
                    n_phase      = (i_byte == '0) ? tlvf_pkg::PH_TAG1 : tlvf_pkg::PH_VALUE;
                end
                tlvf_pkg::PH_VALUE: begin
                    if (r_matches) begin
                        data_valid          = 1'b1;
                        data_item.item_kind = tlvf_pkg::KIND_VALUE;
                        data_item.payload   = i_byte;
                    end
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = tlvf_pkg::PH_TAG1;
                        if (r_matches)
                            n_done = 1'b1;
                    end
                end
                default: n_phase = tlvf_pkg::PH_TAG1;
            endcase
        end

        // status looks at the state after this byte
        status_item.item_kind = tlvf_pkg::KIND_STATUS;
        if (n_recorded) begin
            status_item.tag_found = 1'b1;
            status_item.cut_short = !n_done;
        end else if (n_phase == tlvf_pkg::PH_LEN && n_matches) begin
            status_item.tag_found = 1'b1;
            status_item.cut_short = 1'b1;
        end

        if (i_eos) begin
            n_phase      = tlvf_pkg::PH_TAG1;
            n_matches    = 1'b0;
            n_bytes_left = '0;
            n_done       = 1'b0;
            n_recorded   = 1'b0;
        end
    end

    always_comb begin
        o_push.push0 = i_fire && (data_valid || i_eos);
        o_push.push1 = i_fire && data_valid && i_eos;
        o_push.item0 = data_valid ? data_item : status_item;
        o_push.item1 = status_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tlvf_pkg::PH_TAG1;
            r_matches    <= 1'b0;
            r_bytes_left <= '0;
            r_done       <= 1'b0;
            r_recorded   <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_matches    <= n_matches;
            r_bytes_left <= n_bytes_left;
            r_done       <= n_done;
            r_recorded   <= n_recorded;
        end
    end

endmodule

@@ hw/rtl/tlvf_out_fifo.sv @@
// Small result queue in flip-flops: up to two writes per cycle, one read.
// Depends on tlvf_pkg.
module tlvf_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlvf_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_room2,
    output logic             o_valid,
    output tlvf_pkg::t_item  o_item
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    tlvf_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_p1 = ptr_inc(r_wr_ptr);
    assign do_pop    = i_pop && (r_count != '0);
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign o_room2   = (r_count <= ROOM_LIMIT);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.push1)
            n_wr_ptr = ptr_inc(wr_ptr_p1);
        else if (i_push.push0)
            n_wr_ptr = wr_ptr_p1;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.push0) + CNT_W'(i_push.push1) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0)
            r_mem[r_wr_ptr] <= i_push.item0;
        if (i_push.push1)
            r_mem[wr_ptr_p1] <= i_push.item1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/tlv_tag_value_finder.sv @@
// TLV tag value finder: input register, scan stage and result queue.
// Path: each byte is held in the input register, then its results are written into
// the result queue, from which they can be taken.
// Throughput: one byte per cycle; a final byte also adds a status item, and the
// queue (FIFO_DEPTH entries) accepts a byte only while two free slots remain.
// Reset (synchronous, active low) clears scan state, queue and target registers.
// Depends on tlvf_pkg, tlvf_scan and tlvf_out_fifo.
module tlv_tag_value_finder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [tlvf_pkg::BYTE_W-1:0]  i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tlvf_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_end_of_string,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_item_kind,
    output logic [tlvf_pkg::BYTE_W-1:0]  o_payload,
    output logic                         o_tag_found,
    output logic                         o_cut_short
);

    logic [tlvf_pkg::BYTE_W-1:0] r_target_first;
    logic [tlvf_pkg::BYTE_W-1:0] r_target_second;

    logic                        r_in_valid;
    logic [tlvf_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_eos;

    logic            room2;
    logic            fire;
    tlvf_pkg::t_push push;
    tlvf_pkg::t_item head;

    assign fire       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_first  <= '0;
            r_target_second <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlvf_pkg::CFG_TARGET_FIRST:  r_target_first  <= i_cfg_data;
                tlvf_pkg::CFG_TARGET_SECOND: r_target_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (!o_in_stall)
            r_in_valid <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
    end

    tlvf_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_byte          (r_in_byte),
        .i_eos           (r_in_eos),
        .i_target_first  (r_target_first),
        .i_target_second (r_target_second),
        .o_push          (push)
    );

    tlvf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .o_item  (head)
    );

    assign o_item_kind = head.item_kind;
    assign o_payload   = head.payload;
    assign o_tag_found = head.tag_found;
    assign o_cut_short = head.cut_short;

endmodule
